[sv/rsd_pkg.sv]
// shared constants and the cordic arctangent table for the radial stick deadzone
// no dependencies
`default_nettype none
package rsd_pkg;
	localparam int SAMPLE_WIDTH_DEF  = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int SCALE_W = 32;
	localparam int DATA_W  = 35;
	localparam int Z_W     = 32;
	localparam int R_W     = 32;
	localparam int CMP_W   = 40;
	localparam int DZ_W    = 15;
	localparam int MAG_W   = 15;
	localparam int OUT_W   = 16;
	localparam int ANG_W   = 16;
	localparam int PROJ_QW = 17;
	localparam int PROD_W  = 64;
	localparam int INV_SHIFT = 30;
	localparam logic [29:0]      INV_GAIN  = 30'd652032874;
	localparam logic [MAG_W-1:0] OUT_ONE   = 15'd32767;
	localparam logic [DZ_W-1:0]  DZ_RESET  = 15'd7849;
	localparam logic [Z_W-1:0]   Z_HALF    = 32'h8000_0000;
	localparam logic [Z_W-1:0]   ANG_ROUND = 32'h0000_8000;

	function automatic logic [Z_W-1:0] atan_turn(input int i);
		logic [Z_W-1:0] a;
		case (i)
			0:  a = 32'h20000000;
			1:  a = 32'h12E4051E;
			2:  a = 32'h09FB385B;
			3:  a = 32'h051111D4;
			4:  a = 32'h028B0D43;
			5:  a = 32'h0145D7E1;
			6:  a = 32'h00A2F61E;
			7:  a = 32'h00517C55;
			8:  a = 32'h0028BE53;
			9:  a = 32'h00145F2F;
			10: a = 32'h000A2F98;
			11: a = 32'h000517CC;
			12: a = 32'h00028BE6;
			13: a = 32'h000145F3;
			14: a = 32'h0000A2FA;
			15: a = 32'h0000517D;
			16: a = 32'h000028BE;
			17: a = 32'h0000145F;
			18: a = 32'h00000A30;
			19: a = 32'h00000518;
			20: a = 32'h0000028C;
			21: a = 32'h00000146;
			22: a = 32'h000000A3;
			23: a = 32'h00000051;
			default: a = '0;
		endcase
		return a;
	endfunction
endpackage
`default_nettype wire

[sv/rsd_cordic.sv]
// pipelined vectoring cordic: one register stage per rotation, sample carried along
// depends on rsd_pkg
`default_nettype none
module rsd_cordic #(
	parameter int SW     = rsd_pkg::SAMPLE_WIDTH_DEF,
	parameter int STAGES = rsd_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_v,
	input  logic signed [SW-1:0]                x,
	input  logic signed [SW-1:0]                y,
	output logic                                out_v,
	output logic signed [rsd_pkg::DATA_W-1:0]   out_cx,
	output logic [rsd_pkg::Z_W-1:0]             out_z,
	output logic signed [SW-1:0]                out_sx,
	output logic signed [SW-1:0]                out_sy
);
	import rsd_pkg::*;
	localparam int G = SCALE_W - SW;

	logic                     v_s  [STAGES+1];
	logic signed [DATA_W-1:0] cx_s [STAGES+1];
	logic signed [DATA_W-1:0] cy_s [STAGES+1];
	logic [Z_W-1:0]           z_s  [STAGES+1];
	logic signed [SW-1:0]     sx_s [STAGES+1];
	logic signed [SW-1:0]     sy_s [STAGES+1];

	logic signed [DATA_W-1:0] xe, ye;
	assign xe = DATA_W'(x) <<< G;
	assign ye = DATA_W'(y) <<< G;

	// half-plane fold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= x[SW-1] ? -xe : xe;
			cy_s[0] <= x[SW-1] ? -ye : ye;
			z_s[0]  <= x[SW-1] ? Z_HALF : '0;
			sx_s[0] <= x;
			sy_s[0] <= y;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		logic signed [DATA_W-1:0] dx, dy;
		logic                     up;
		assign dx = cy_s[i] >>> i;
		assign dy = cx_s[i] >>> i;
		assign up = !cy_s[i][DATA_W-1];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				cx_s[i+1] <= up ? cx_s[i] + dx : cx_s[i] - dx;
				cy_s[i+1] <= up ? cy_s[i] - dy : cy_s[i] + dy;
				z_s[i+1]  <= up ? z_s[i] + atan_turn(i) : z_s[i] - atan_turn(i);
				sx_s[i+1] <= sx_s[i];
				sy_s[i+1] <= sy_s[i];
			end
		end
	end

	assign out_v  = v_s[STAGES];
	assign out_cx = cx_s[STAGES];
	assign out_z  = z_s[STAGES];
	assign out_sx = sx_s[STAGES];
	assign out_sy = sy_s[STAGES];
endmodule
`default_nettype wire

[sv/rsd_div.sv]
// pipelined restoring divider, one quotient bit per register stage, side data carried along
// depends on rsd_pkg only through its users; dividend high part must stay below the divisor
`default_nettype none
module rsd_div #(
	parameter int DW = 32,
	parameter int QW = 15,
	parameter int PW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [DW+QW-1:0] n,
	input  logic [DW-1:0]    d,
	input  logic [PW-1:0]    pl,
	output logic             out_v,
	output logic [QW-1:0]    q,
	output logic [PW-1:0]    out_pl
);
	logic          v_s   [QW+1];
	logic [DW-1:0] rem_s [QW+1];
	logic [QW-1:0] low_s [QW+1];
	logic [DW-1:0] d_s   [QW+1];
	logic [PW-1:0] pl_s  [QW+1];

	assign v_s[0]   = in_v;
	assign rem_s[0] = n[DW+QW-1:QW];
	assign low_s[0] = n[QW-1:0];
	assign d_s[0]   = d;
	assign pl_s[0]  = pl;

	for (genvar k = 0; k < QW; k++) begin : g_bit
		logic [DW:0] t;
		logic        ge;
		assign t  = {rem_s[k], low_s[k][QW-1]};
		assign ge = t >= {1'b0, d_s[k]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? DW'(t - {1'b0, d_s[k]}) : t[DW-1:0];
				low_s[k+1] <= {low_s[k][QW-2:0], ge};
				d_s[k+1]   <= d_s[k];
				pl_s[k+1]  <= pl_s[k];
			end
		end
	end

	assign out_v  = v_s[QW];
	assign q      = low_s[QW];
	assign out_pl = pl_s[QW];
endmodule
`default_nettype wire

[sv/radial_stick_deadzone.sv]
// top level: cordic, gain removal, deadzone rescale divider, projection dividers, output queue
// depends on rsd_pkg, rsd_cordic, rsd_div
//
//  channel  | handshake             | payload
//  input    | in_valid / in_stall   | stick_x, stick_y
//  config   | cfg_valid / cfg_ready | cfg_data (deadzone radius)
//  output   | out_valid / out_stall | out_x, out_y, out_magnitude, out_angle, outside_deadzone
//
// one item per cycle while in_stall is low; the path from input edge to output edge runs through
// fold and cordic, gain multiplier, rescale setup, 15-bit magnitude divider,
// projection setup, 17-bit projection dividers and the output queue
// reset clears all valid bits and loads the deadzone radius with 7849
// a two-entry output queue absorbs stalls; in_stall rises only when both entries are full
`default_nettype none
module radial_stick_deadzone #(
	parameter int SAMPLE_WIDTH  = rsd_pkg::SAMPLE_WIDTH_DEF,
	parameter int CORDIC_STAGES = rsd_pkg::CORDIC_STAGES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]   stick_x,
	input  logic signed [SAMPLE_WIDTH-1:0]   stick_y,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rsd_pkg::DZ_W-1:0]         cfg_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [rsd_pkg::OUT_W-1:0] out_x,
	output logic signed [rsd_pkg::OUT_W-1:0] out_y,
	output logic [rsd_pkg::MAG_W-1:0]        out_magnitude,
	output logic signed [rsd_pkg::ANG_W-1:0] out_angle,
	output logic                             outside_deadzone
);
	import rsd_pkg::*;
	localparam int SW = SAMPLE_WIDTH;
	localparam int G  = SCALE_W - SW;
	localparam int MAG_NW = R_W + MAG_W;
	localparam int PRJ_NW = R_W + PROJ_QW;
	localparam int MAG_PW = 1 + Z_W + R_W + 2 * SW;
	localparam int PRJ_PW = 1 + Z_W + 1 + MAG_W;

	typedef struct packed {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic [MAG_W-1:0]        mag;
		logic signed [ANG_W-1:0] ang;
		logic                    outs;
	} res_t;

	logic [DZ_W-1:0] dz_q;
	logic [1:0]      cnt_q;
	logic            en, push, pop;

	assign cfg_ready = 1'b1;
	assign en        = cnt_q != 2'd2;
	assign in_stall  = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= DZ_RESET;
		end else if (cfg_valid) begin
			dz_q <= cfg_data;
		end
	end

	// cordic
	logic                     c_v;
	logic signed [DATA_W-1:0] c_cx;
	logic [Z_W-1:0]           c_z;
	logic signed [SW-1:0]     c_sx, c_sy;

	rsd_cordic #(.SW(SW), .STAGES(CORDIC_STAGES)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(in_valid),
		.x(stick_x), .y(stick_y),
		.out_v(c_v), .out_cx(c_cx), .out_z(c_z), .out_sx(c_sx), .out_sy(c_sy)
	);

	// gain removal
	logic                 v_s1;
	logic [PROD_W-1:0]    prod_s1;
	logic [Z_W-1:0]       z_s1;
	logic signed [SW-1:0] sx_s1, sy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= c_v;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(c_cx[33:0]) * PROD_W'(INV_GAIN);
			z_s1    <= c_z;
			sx_s1   <= c_sx;
			sy_s1   <= c_sy;
		end
	end

	// deadzone test and rescale numerator
	logic [R_W-1:0]   r1;
	logic [CMP_W-1:0] rw, dzg, full, rs;
	logic [R_W-1:0]   num, den;
	logic             outs1;

	assign r1    = prod_s1[INV_SHIFT+R_W-1:INV_SHIFT];
	assign rw    = CMP_W'(r1);
	assign dzg   = CMP_W'(dz_q) << G;
	assign full  = CMP_W'((64'd1 << (SW - 1)) - 64'd1) << G;
	assign outs1 = rw > dzg;
	assign rs    = rw > full ? full : rw;
	assign num   = rs > dzg ? R_W'(rs - dzg) : '0;
	assign den   = full > dzg ? R_W'(full - dzg) : '0;

	logic                 v_s2;
	logic [MAG_NW-1:0]    n_s2;
	logic [R_W-1:0]       d_s2;
	logic [MAG_PW-1:0]    pl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			n_s2  <= MAG_NW'(num) * MAG_NW'(OUT_ONE) + MAG_NW'(den >> 1);
			d_s2  <= (den == '0) ? R_W'(1) : den;
			pl_s2 <= {outs1, z_s1, r1, sx_s1, sy_s1};
		end
	end

	// magnitude divider
	logic                 m_v;
	logic [MAG_W-1:0]     m_q;
	logic [MAG_PW-1:0]    m_pl;
	logic                 m_outs;
	logic [Z_W-1:0]       m_z;
	logic [R_W-1:0]       m_r;
	logic signed [SW-1:0] m_sx, m_sy;

	rsd_div #(.DW(R_W), .QW(MAG_W), .PW(MAG_PW)) u_div_mag (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s2),
		.n(n_s2), .d(d_s2), .pl(pl_s2),
		.out_v(m_v), .q(m_q), .out_pl(m_pl)
	);
	assign {m_outs, m_z, m_r, m_sx, m_sy} = m_pl;

	// projection numerators
	logic [SW-1:0]     ax, ay;
	logic [R_W-1:0]    axs, ays;
	assign ax  = m_sx[SW-1] ? SW'(-m_sx) : SW'(m_sx);
	assign ay  = m_sy[SW-1] ? SW'(-m_sy) : SW'(m_sy);
	assign axs = R_W'(ax) << G;
	assign ays = R_W'(ay) << G;

	logic              v_s3;
	logic [PRJ_NW-1:0] nx_s3, ny_s3;
	logic [R_W-1:0]    r_s3;
	logic [PRJ_PW-1:0] pl_s3;
	logic              sy_neg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= m_v;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s3     <= PRJ_NW'(axs) * PRJ_NW'(m_q) + PRJ_NW'(m_r >> 1);
			ny_s3     <= PRJ_NW'(ays) * PRJ_NW'(m_q) + PRJ_NW'(m_r >> 1);
			r_s3      <= (m_r == '0) ? R_W'(1) : m_r;
			pl_s3     <= {m_outs, m_z, m_sx[SW-1], m_q};
			sy_neg_s3 <= m_sy[SW-1];
		end
	end

	// projection dividers
	logic               px_v, py_v;
	logic [PROJ_QW-1:0] px_q, py_q;
	logic [PRJ_PW-1:0]  px_pl;
	logic               py_pl;

	rsd_div #(.DW(R_W), .QW(PROJ_QW), .PW(PRJ_PW)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s3),
		.n(nx_s3), .d(r_s3), .pl(pl_s3),
		.out_v(px_v), .q(px_q), .out_pl(px_pl)
	);
	rsd_div #(.DW(R_W), .QW(PROJ_QW), .PW(1)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s3),
		.n(ny_s3), .d(r_s3), .pl(sy_neg_s3),
		.out_v(py_v), .q(py_q), .out_pl(py_pl)
	);

	// final clamp, signs and angle rounding
	logic             f_outs, f_xneg;
	logic [Z_W-1:0]   f_z, zr;
	logic [MAG_W-1:0] f_mag, cpx, cpy;
	res_t             res;

	assign {f_outs, f_z, f_xneg, f_mag} = px_pl;
	assign cpx = (px_q > PROJ_QW'(f_mag)) ? f_mag : px_q[MAG_W-1:0];
	assign cpy = (py_q > PROJ_QW'(f_mag)) ? f_mag : py_q[MAG_W-1:0];
	assign zr  = f_z + ANG_ROUND;

	always_comb begin
		res = '0;
		if (f_outs) begin
			res.x    = f_xneg ? -OUT_W'(cpx) : OUT_W'(cpx);
			res.y    = py_pl ? -OUT_W'(cpy) : OUT_W'(cpy);
			res.mag  = f_mag;
			res.ang  = zr[Z_W-1:Z_W-ANG_W];
			res.outs = 1'b1;
		end
	end

	// output queue
	res_t head_q, tail_q;
	assign push = en && px_v && py_v;
	assign pop  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
	always_ff @(posedge clk) begin
		if (pop) begin
			head_q <= (cnt_q == 2'd2) ? tail_q : res;
			if (push && cnt_q == 2'd2) begin
				tail_q <= res;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= res;
			end else begin
				tail_q <= res;
			end
		end
	end

	assign out_valid        = cnt_q != 2'd0;
	assign out_x            = head_q.x;
	assign out_y            = head_q.y;
	assign out_magnitude    = head_q.mag;
	assign out_angle        = head_q.ang;
	assign outside_deadzone = head_q.outs;

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("output queue overflow");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |=> $stable(px_v) && $stable(px_q))
		else $error("pipeline moved while queue full");
	a_lanes: assert property (@(posedge clk) disable iff (!arst_n) px_v == py_v)
		else $error("projection lanes out of step");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1 && pop && !push) |=> !out_valid)
		else $error("queue did not drain");
	a_inside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !outside_deadzone) |-> (out_magnitude == '0 && out_angle == '0))
		else $error("nonzero item inside deadzone");
`endif
endmodule
`default_nettype wire
